[rtl/tbs_pkg.sv]
// Shared types and constants of the texture bilinear sampler.
// No dependencies; every other file of the block but tbs_ram imports this package.
`timescale 1ns / 1ps

package tbs_pkg;

    // Configuration port
    localparam int   CFG_W          = 9;
    localparam int   CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 1'd1;

    // Request mode codes
    localparam logic MODE_SAMPLE = 1'b1;

    // Fixed-point constants
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [15:0] GREY_Q8 = 16'd32640;

    typedef struct packed {
        logic               mode;
        logic [15:0]        texel_index;
        logic [7:0]         texel_red;
        logic [7:0]         texel_green;
        logic [7:0]         texel_blue;
        logic signed [31:0] coord_u;
        logic signed [31:0] coord_v;
    } req_t;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
    } res_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // What an item does at the texel memory
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_SAMPLE,
        OP_GREY
    } op_t;

endpackage

[rtl/tbs_ram.sv]
// Generic single-port synchronous RAM, one access per cycle, registered read.
// No dependencies.
`timescale 1ns / 1ps

module tbs_ram #(
    parameter int  WIDTH = 24,
    parameter int  DEPTH = 65536,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tbs_coord.sv]
// Coordinate pipeline: request capture, wrap/clamp and scaling, neighbor
// rows and columns with row base addresses. Depends on tbs_pkg.
`timescale 1ns / 1ps

module tbs_coord
    import tbs_pkg::*;
#(
    parameter int  MAX_SIDE = 256,
    localparam int SW       = $clog2(MAX_SIDE + 1),
    localparam int AW       = $clog2(MAX_SIDE * MAX_SIDE)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             req_valid,
    input  req_t             req_data,
    input  logic [CFG_W-1:0] tex_width,
    input  logic [CFG_W-1:0] tex_height,
    output logic             crd_valid,
    output op_t              crd_op,
    output logic [15:0]      crd_index,
    output rgb_t             crd_texel,
    output logic [SW-1:0]    crd_x0,
    output logic [SW-1:0]    crd_x1,
    output logic [AW-1:0]    crd_base0,
    output logic [AW-1:0]    crd_base1,
    output logic [15:0]      crd_fx,
    output logic [15:0]      crd_fy
);

    localparam int CW  = (SW > CFG_W) ? SW : CFG_W;
    localparam int PXW = 16 + SW;
    localparam int PYW = 17 + SW;
    localparam int BW  = 2 * SW;

    function automatic logic [SW-1:0] side_sat(input logic [CFG_W-1:0] s);
        if (CW'(s) > CW'(MAX_SIDE))
            return SW'(MAX_SIDE);
        else
            return SW'(s);
    endfunction

    logic [SW-1:0] w;
    logic [SW-1:0] h;
    logic [SW-1:0] wm1;
    logic [SW-1:0] hm1;

    assign w   = side_sat(tex_width);
    assign h   = side_sat(tex_height);
    assign wm1 = w - 1'b1;
    assign hm1 = h - 1'b1;

    // stage 1: captured request
    logic f1_valid_reg;
    req_t f1_req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else if (adv)
            f1_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            f1_req_reg <= req_data;
    end

    // stage 2: u fraction, v clamp, scale by side-1
    logic [16:0]    vc;
    op_t            op_next;
    logic [PXW-1:0] px_next;
    logic [PYW-1:0] py_next;

    always_comb
    begin
        if (f1_req_reg.coord_v[31])
            vc = '0;
        else if (f1_req_reg.coord_v > $signed(32'(ONE_Q16)))
            vc = ONE_Q16;
        else
            vc = f1_req_reg.coord_v[16:0];

        if (f1_req_reg.mode != MODE_SAMPLE)
            op_next = OP_WRITE;
        else if (w == '0 || h == '0)
            op_next = OP_GREY;
        else
            op_next = OP_SAMPLE;
    end

    assign px_next = PXW'(f1_req_reg.coord_u[15:0]) * PXW'(wm1);
    assign py_next = PYW'(vc) * PYW'(hm1);

    logic           f2_valid_reg;
    op_t            f2_op_reg;
    logic [15:0]    f2_index_reg;
    rgb_t           f2_texel_reg;
    logic [PXW-1:0] f2_px_reg;
    logic [PYW-1:0] f2_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f2_valid_reg <= 1'b0;
        else if (adv)
            f2_valid_reg <= f1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f2_op_reg    <= op_next;
            f2_index_reg <= f1_req_reg.texel_index;
            f2_texel_reg <= '{red:   f1_req_reg.texel_red,
                              green: f1_req_reg.texel_green,
                              blue:  f1_req_reg.texel_blue};
            f2_px_reg    <= px_next;
            f2_py_reg    <= py_next;
        end
    end

    // stage 3: neighbors and row bases
    logic [SW-1:0] x0;
    logic [SW-1:0] y0;
    logic [SW:0]   x0p;
    logic [SW:0]   y0p;
    logic [SW-1:0] x1;
    logic [SW-1:0] y1;
    logic [BW-1:0] prod0;
    logic [BW-1:0] prod1;

    assign x0    = f2_px_reg[16 +: SW];
    assign y0    = f2_py_reg[16 +: SW];
    assign x0p   = {1'b0, x0} + 1'b1;
    assign y0p   = {1'b0, y0} + 1'b1;
    assign x1    = (x0p == {1'b0, w}) ? '0 : x0p[SW-1:0];  // wrap right edge
    assign y1    = (y0p >= {1'b0, h}) ? hm1 : y0p[SW-1:0]; // clamp bottom row
    assign prod0 = BW'(y0) * BW'(w);
    assign prod1 = BW'(y1) * BW'(w);

    logic          f3_valid_reg;
    op_t           f3_op_reg;
    logic [15:0]   f3_index_reg;
    rgb_t          f3_texel_reg;
    logic [SW-1:0] f3_x0_reg;
    logic [SW-1:0] f3_x1_reg;
    logic [AW-1:0] f3_base0_reg;
    logic [AW-1:0] f3_base1_reg;
    logic [15:0]   f3_fx_reg;
    logic [15:0]   f3_fy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f3_valid_reg <= 1'b0;
        else if (adv)
            f3_valid_reg <= f2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f3_op_reg    <= f2_op_reg;
            f3_index_reg <= f2_index_reg;
            f3_texel_reg <= f2_texel_reg;
            f3_x0_reg    <= x0;
            f3_x1_reg    <= x1;
            f3_base0_reg <= prod0[AW-1:0];
            f3_base1_reg <= prod1[AW-1:0];
            f3_fx_reg    <= f2_px_reg[15:0];
            f3_fy_reg    <= f2_py_reg[15:0];
        end
    end

    assign crd_valid = f3_valid_reg;
    assign crd_op    = f3_op_reg;
    assign crd_index = f3_index_reg;
    assign crd_texel = f3_texel_reg;
    assign crd_x0    = f3_x0_reg;
    assign crd_x1    = f3_x1_reg;
    assign crd_base0 = f3_base0_reg;
    assign crd_base1 = f3_base1_reg;
    assign crd_fx    = f3_fx_reg;
    assign crd_fy    = f3_fy_reg;

endmodule

[rtl/tbs_fetch.sv]
// Texel memory and its access sequencer: one write or one of four neighbor
// reads per cycle unless stalled, collection of the four texels. Depends on tbs_pkg, tbs_ram.
`timescale 1ns / 1ps

module tbs_fetch
    import tbs_pkg::*;
#(
    parameter int  MAX_SIDE = 256,
    localparam int SW       = $clog2(MAX_SIDE + 1),
    localparam int AW       = $clog2(MAX_SIDE * MAX_SIDE)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          crd_valid,
    input  op_t           crd_op,
    input  logic [15:0]   crd_index,
    input  rgb_t          crd_texel,
    input  logic [SW-1:0] crd_x0,
    input  logic [SW-1:0] crd_x1,
    input  logic [AW-1:0] crd_base0,
    input  logic [AW-1:0] crd_base1,
    input  logic [15:0]   crd_fx,
    input  logic [15:0]   crd_fy,
    output logic          take,
    output logic          tex_valid,
    output logic          tex_grey,
    output logic [15:0]   tex_fx,
    output logic [15:0]   tex_fy,
    output rgb_t          tex_p00,
    output rgb_t          tex_p10,
    output rgb_t          tex_p01,
    output rgb_t          tex_p11
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;

    // read order of the four neighbors
    localparam logic [1:0] SLOT_P00 = 2'd0;
    localparam logic [1:0] SLOT_P10 = 2'd1;
    localparam logic [1:0] SLOT_P01 = 2'd2;
    localparam logic [1:0] SLOT_P11 = 2'd3;

    logic          m_valid_reg;
    logic [1:0]    m_cnt_reg;
    op_t           m_op_reg;
    logic [15:0]   m_index_reg;
    rgb_t          m_texel_reg;
    logic [SW-1:0] m_x0_reg;
    logic [SW-1:0] m_x1_reg;
    logic [AW-1:0] m_base0_reg;
    logic [AW-1:0] m_base1_reg;
    logic [15:0]   m_fx_reg;
    logic [15:0]   m_fy_reg;
    logic          m_last;

    assign m_last = (m_op_reg != OP_SAMPLE) || (m_cnt_reg == SLOT_P11);
    assign take   = !m_valid_reg || m_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            m_cnt_reg   <= '0;
        end
        else if (adv)
        begin
            if (take)
            begin
                m_valid_reg <= crd_valid;
                m_cnt_reg   <= '0;
            end
            else
            begin
                m_cnt_reg <= m_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && take)
        begin
            m_op_reg    <= crd_op;
            m_index_reg <= crd_index;
            m_texel_reg <= crd_texel;
            m_x0_reg    <= crd_x0;
            m_x1_reg    <= crd_x1;
            m_base0_reg <= crd_base0;
            m_base1_reg <= crd_base1;
            m_fx_reg    <= crd_fx;
            m_fy_reg    <= crd_fy;
        end
    end

    // memory port
    logic [31:0]   wr_idx32;
    logic          wr_ok;
    logic [AW-1:0] rd_addr;
    logic          ram_en;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    rgb_t          ram_rdata;

    assign wr_idx32 = 32'(m_index_reg);
    assign wr_ok    = wr_idx32 < 32'(DEPTH);

    always_comb
    begin
        case (m_cnt_reg)
            SLOT_P00: rd_addr = m_base0_reg + AW'(m_x0_reg);
            SLOT_P10: rd_addr = m_base0_reg + AW'(m_x1_reg);
            SLOT_P01: rd_addr = m_base1_reg + AW'(m_x0_reg);
            default:  rd_addr = m_base1_reg + AW'(m_x1_reg);
        endcase
    end

    assign ram_we   = (m_op_reg == OP_WRITE);
    assign ram_en   = adv && m_valid_reg &&
                      ((ram_we && wr_ok) || (m_op_reg == OP_SAMPLE));
    assign ram_addr = ram_we ? wr_idx32[AW-1:0] : rd_addr;

    tbs_ram #(
        .WIDTH ($bits(rgb_t)),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (m_texel_reg),
        .rdata (ram_rdata)
    );

    // read return stage
    logic        r_rd_reg;
    logic        r_last_reg;
    logic [1:0]  r_slot_reg;
    logic        r_grey_reg;
    logic [15:0] r_fx_reg;
    logic [15:0] r_fy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_rd_reg   <= 1'b0;
            r_last_reg <= 1'b0;
        end
        else if (adv)
        begin
            r_rd_reg   <= m_valid_reg && (m_op_reg == OP_SAMPLE);
            r_last_reg <= m_valid_reg && m_last && (m_op_reg != OP_WRITE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_slot_reg <= m_cnt_reg;
            r_grey_reg <= (m_op_reg == OP_GREY);
            r_fx_reg   <= m_fx_reg;
            r_fy_reg   <= m_fy_reg;
        end
    end

    // first three texels wait here; the fourth is taken straight off the RAM
    rgb_t c00_reg;
    rgb_t c10_reg;
    rgb_t c01_reg;

    always_ff @(posedge clk)
    begin
        if (adv && r_rd_reg)
        begin
            case (r_slot_reg)
                SLOT_P00: c00_reg <= ram_rdata;
                SLOT_P10: c10_reg <= ram_rdata;
                SLOT_P01: c01_reg <= ram_rdata;
                default:  ;
            endcase
        end
    end

    assign tex_valid = r_last_reg;
    assign tex_grey  = r_grey_reg;
    assign tex_fx    = r_fx_reg;
    assign tex_fy    = r_fy_reg;
    assign tex_p00   = c00_reg;
    assign tex_p10   = c10_reg;
    assign tex_p01   = c01_reg;
    assign tex_p11   = ram_rdata;

endmodule

[rtl/tbs_blend.sv]
// Two-stage bilinear blend of three color channels, Q8.8 truncation,
// grey substitution when no texture. Depends on tbs_pkg.
`timescale 1ns / 1ps

module tbs_blend
    import tbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        tex_valid,
    input  logic        tex_grey,
    input  logic [15:0] tex_fx,
    input  logic [15:0] tex_fy,
    input  rgb_t        tex_p00,
    input  rgb_t        tex_p10,
    input  rgb_t        tex_p01,
    input  rgb_t        tex_p11,
    output logic        blend_valid,
    output res_t        blend_data
);

    function automatic logic [23:0] lerp_x(input logic [7:0]  a,
                                           input logic [7:0]  b,
                                           input logic [16:0] w0,
                                           input logic [15:0] f);
        logic [24:0] s;
        s = 25'(a) * 25'(w0) + 25'(b) * 25'(f);
        return s[23:0];
    endfunction

    function automatic logic [15:0] lerp_y(input logic [23:0] t,
                                           input logic [23:0] b,
                                           input logic [16:0] w0,
                                           input logic [15:0] f);
        logic [40:0] s;
        s = 41'(t) * 41'(w0) + 41'(b) * 41'(f);
        return s[39:24];
    endfunction

    logic [16:0] wx0;
    logic [7:0]  a00 [3];
    logic [7:0]  a10 [3];
    logic [7:0]  a01 [3];
    logic [7:0]  a11 [3];

    assign wx0 = ONE_Q16 - 17'(tex_fx);

    always_comb
    begin
        a00[0] = tex_p00.red;  a00[1] = tex_p00.green;  a00[2] = tex_p00.blue;
        a10[0] = tex_p10.red;  a10[1] = tex_p10.green;  a10[2] = tex_p10.blue;
        a01[0] = tex_p01.red;  a01[1] = tex_p01.green;  a01[2] = tex_p01.blue;
        a11[0] = tex_p11.red;  a11[1] = tex_p11.green;  a11[2] = tex_p11.blue;
    end

    // stage 1: horizontal blend of top and bottom rows
    logic        b1_valid_reg;
    logic        b1_grey_reg;
    logic [15:0] b1_fy_reg;
    logic [23:0] b1_top_reg [3];
    logic [23:0] b1_bot_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b1_valid_reg <= 1'b0;
        else if (adv)
            b1_valid_reg <= tex_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_grey_reg <= tex_grey;
            b1_fy_reg   <= tex_fy;
            for (int c = 0; c < 3; c++)
            begin
                b1_top_reg[c] <= lerp_x(a00[c], a10[c], wx0, tex_fx);
                b1_bot_reg[c] <= lerp_x(a01[c], a11[c], wx0, tex_fx);
            end
        end
    end

    // stage 2: vertical blend, keep bits 39..24
    logic [16:0] wy0;
    res_t        res_next;

    assign wy0 = ONE_Q16 - 17'(b1_fy_reg);

    always_comb
    begin
        if (b1_grey_reg)
        begin
            res_next = '{out_red: GREY_Q8, out_green: GREY_Q8, out_blue: GREY_Q8};
        end
        else
        begin
            res_next.out_red   = lerp_y(b1_top_reg[0], b1_bot_reg[0], wy0, b1_fy_reg);
            res_next.out_green = lerp_y(b1_top_reg[1], b1_bot_reg[1], wy0, b1_fy_reg);
            res_next.out_blue  = lerp_y(b1_top_reg[2], b1_bot_reg[2], wy0, b1_fy_reg);
        end
    end

    logic b2_valid_reg;
    res_t b2_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b2_valid_reg <= 1'b0;
        else if (adv)
            b2_valid_reg <= b1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            b2_data_reg <= res_next;
    end

    assign blend_valid = b2_valid_reg;
    assign blend_data  = b2_data_reg;

endmodule

[rtl/texture_bilinear_sampler_unit.sv]
// Top level of the texture bilinear sampler: configuration registers,
// pipeline control and result register. Depends on tbs_pkg, tbs_coord,
// tbs_fetch, tbs_blend.
`timescale 1ns / 1ps

//  channel   | valid      | stall      | payload
//  ----------+------------+------------+------------------------------------
//  request   | req_valid  | req_stall  | req_data  (req_t: write or sample)
//  result    | res_valid  | res_stall  | res_data  (res_t: Q8.8 RGB)
//  config    | cfg_we     | -          | cfg_index, cfg_data (tex_width/height)
//
// A texel write takes a single access of the memory port, so writes
// stream at one per cycle unless res_stall freezes the pipeline. A sample
// reads its four neighbors through the single port of the texel memory,
// one per cycle unless stalled.
// Reset clears tex_width/tex_height and all pipeline valids; the texel store
// is not cleared and holds garbage until written.
// res_stall with a result waiting freezes the whole pipeline, which then
// stalls requests; a sample in its read phase also stalls requests.

module texture_bilinear_sampler_unit
    import tbs_pkg::*;
#(
    parameter int MAX_SIDE = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_t                 res_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);

    // configuration
    logic [CFG_W-1:0] tex_width_reg;
    logic [CFG_W-1:0] tex_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= '0;
            tex_height_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEX_WIDTH:  tex_width_reg  <= cfg_data;
                CFG_TEX_HEIGHT: tex_height_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Pipeline control: everything past the request stage moves together
    // unless the result register is full and stalled. The coordinate stages
    // additionally wait while the sequencer is still reading neighbors.
    logic o_valid_reg;
    res_t o_data_reg;
    logic adv;
    logic take;
    logic front_adv;

    assign adv       = !(o_valid_reg && res_stall);
    assign front_adv = adv && take;
    assign req_stall = !front_adv;

    logic          crd_valid;
    op_t           crd_op;
    logic [15:0]   crd_index;
    rgb_t          crd_texel;
    logic [SW-1:0] crd_x0;
    logic [SW-1:0] crd_x1;
    logic [AW-1:0] crd_base0;
    logic [AW-1:0] crd_base1;
    logic [15:0]   crd_fx;
    logic [15:0]   crd_fy;

    tbs_coord #(
        .MAX_SIDE (MAX_SIDE)
    ) u_coord (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (front_adv),
        .req_valid  (req_valid),
        .req_data   (req_data),
        .tex_width  (tex_width_reg),
        .tex_height (tex_height_reg),
        .crd_valid  (crd_valid),
        .crd_op     (crd_op),
        .crd_index  (crd_index),
        .crd_texel  (crd_texel),
        .crd_x0     (crd_x0),
        .crd_x1     (crd_x1),
        .crd_base0  (crd_base0),
        .crd_base1  (crd_base1),
        .crd_fx     (crd_fx),
        .crd_fy     (crd_fy)
    );

    logic        tex_valid;
    logic        tex_grey;
    logic [15:0] tex_fx;
    logic [15:0] tex_fy;
    rgb_t        tex_p00;
    rgb_t        tex_p10;
    rgb_t        tex_p01;
    rgb_t        tex_p11;

    tbs_fetch #(
        .MAX_SIDE (MAX_SIDE)
    ) u_fetch (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .crd_valid (crd_valid),
        .crd_op    (crd_op),
        .crd_index (crd_index),
        .crd_texel (crd_texel),
        .crd_x0    (crd_x0),
        .crd_x1    (crd_x1),
        .crd_base0 (crd_base0),
        .crd_base1 (crd_base1),
        .crd_fx    (crd_fx),
        .crd_fy    (crd_fy),
        .take      (take),
        .tex_valid (tex_valid),
        .tex_grey  (tex_grey),
        .tex_fx    (tex_fx),
        .tex_fy    (tex_fy),
        .tex_p00   (tex_p00),
        .tex_p10   (tex_p10),
        .tex_p01   (tex_p01),
        .tex_p11   (tex_p11)
    );

    logic blend_valid;
    res_t blend_data;

    tbs_blend u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .tex_valid   (tex_valid),
        .tex_grey    (tex_grey),
        .tex_fx      (tex_fx),
        .tex_fy      (tex_fy),
        .tex_p00     (tex_p00),
        .tex_p10     (tex_p10),
        .tex_p01     (tex_p01),
        .tex_p11     (tex_p11),
        .blend_valid (blend_valid),
        .blend_data  (blend_data)
    );

    // result register: holds while stalled, refills whenever it is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (adv)
            o_valid_reg <= blend_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            o_data_reg <= blend_data;
    end

    assign res_valid = o_valid_reg;
    assign res_data  = o_data_reg;

endmodule
